// File: rtl/cbf_pkg.sv
// Shared types and codes for the closable bounded FIFO.
// Used by the storage cells, the statistics counters and the top level.
package cbf_pkg;

  // Width of every statistics counter.
  localparam int STAT_W = 32;

  // Command codes carried in the input tuser.
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;

  // Status codes carried in the output tuser.
  localparam logic [2:0] ST_PUSHED        = 3'd0;
  localparam logic [2:0] ST_FULL          = 3'd1;
  localparam logic [2:0] ST_CLOSED_REJECT = 3'd2;
  localparam logic [2:0] ST_VALUE         = 3'd3;
  localparam logic [2:0] ST_LAST          = 3'd4;
  localparam logic [2:0] ST_DONE          = 3'd5;
  localparam logic [2:0] ST_EMPTY         = 3'd6;

  // Per-cycle control broadcast to every storage cell.
  typedef struct packed {
    logic shift;  // every cell takes its upper neighbor's entry (a pop)
    logic load;   // the cell at the tail slot takes the pushed value
  } cell_ctrl_t;

endpackage

// File: rtl/cbf_cell.sv
// One storage cell of the shifting FIFO chain.
// Depends on cbf_pkg for the cell control struct.
module cbf_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5,
  parameter int INDEX      = 0
) (
  input  logic                    clk,
  input  cbf_pkg::cell_ctrl_t     ctrl,
  input  logic [CNT_W-1:0]        count,
  input  logic [DATA_WIDTH-1:0]   push_data,
  input  logic [DATA_WIDTH-1:0]   upper_data,
  output logic [DATA_WIDTH-1:0]   data
);

  logic at_tail;

  assign at_tail = (count == CNT_W'(INDEX));

  // Payload only; no reset needed since entries are read only after a write.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= upper_data;
    end else if (ctrl.load && at_tail) begin
      data <= push_data;
    end
  end

endmodule

// File: rtl/cbf_sat_counter.sv
// Saturating statistics counter with a look-ahead of its next value.
// Depends on cbf_pkg for the counter width.
module cbf_sat_counter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       inc,
  output logic [cbf_pkg::STAT_W-1:0] value,
  output logic [cbf_pkg::STAT_W-1:0] value_next
);

  assign value_next = (inc && (value != '1)) ? value + 1'b1 : value;

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else begin
      value <= value_next;
    end
  end

endmodule

// File: rtl/closable_bounded_fifo_core.sv
// Top level of the closable bounded FIFO: command decode, occupancy control,
// the chain of storage cells and the registered result beat.
// Depends on cbf_pkg, cbf_cell and cbf_sat_counter.
//
// Usage:
//   The slave side takes one command beat: tuser holds the command (push, pop
//   or close) and tdata holds the value to push. Every accepted command beat
//   yields exactly one result beat on the master side: tuser holds the status
//   and tdata the popped value, the occupancy, the peak occupancy, the four
//   saturating statistics counters and the closed flag.
//   Entries live in a row of DEPTH cells. A push writes the cell at the tail
//   slot; a pop reads cell zero and every cell takes its upper neighbor's
//   entry in the same cycle, so the head is always cell zero.
//   The result is registered: the result of a command accepted at one edge is
//   valid on the master side after that edge. Throughput is one command per
//   cycle while the receiver takes each beat, set by the single output
//   register, which is refilled in the same cycle its beat is taken.
//   When the receiver stalls, the result beat holds and the slave side drops
//   tready until it is taken, so no result is lost or repeated.
//   Reset clears the occupancy, the closed flag, the peak and all counters
//   and empties the output register; the cell contents are not cleared.
module closable_bounded_fifo_core #(
  parameter int DEPTH       = 16,
  parameter int DATA_WIDTH  = 32,
  localparam int CNT_W      = $clog2(DEPTH + 1),
  localparam int IN_W       = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_BITS   = DATA_WIDTH + 2 * CNT_W + 4 * cbf_pkg::STAT_W + 1,
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // Command channel.
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // push_value, zero padded
  input  logic [1:0]       s_axis_tuser,   // command
  // Result channel.
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // From bit 0 up: pop_value, occupancy, peak_occupancy, accepted_total,
  // received_total, full_rejects, closed_rejects, is_closed, zero padding.
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic [2:0]       m_axis_tuser    // status
);

  localparam int SW = cbf_pkg::STAT_W;

  // Control state.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] peak;
  logic [CNT_W-1:0] peak_next;
  logic             closed;
  logic             closed_next;

  // Command decode.
  logic                  accept;
  logic [DATA_WIDTH-1:0] push_value;
  logic                  is_push;
  logic                  is_pop;
  logic                  is_close;
  logic                  push_ok;
  logic                  push_full;
  logic                  push_closed;
  logic                  pop_ok;
  logic [2:0]            status_next;
  logic [DATA_WIDTH-1:0] pop_value_next;

  // Statistics.
  logic [SW-1:0] acc_cnt, acc_cnt_next;
  logic [SW-1:0] rcv_cnt, rcv_cnt_next;
  logic [SW-1:0] full_cnt, full_cnt_next;
  logic [SW-1:0] clsd_cnt, clsd_cnt_next;

  // Storage chain.
  cbf_pkg::cell_ctrl_t   cell_ctrl;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];

  logic [OUT_W-1:0] result_word;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push_value    = s_axis_tdata[DATA_WIDTH-1:0];

  assign is_push  = accept && (s_axis_tuser == cbf_pkg::CMD_PUSH);
  assign is_pop   = accept && (s_axis_tuser == cbf_pkg::CMD_POP);
  assign is_close = accept && (s_axis_tuser == cbf_pkg::CMD_CLOSE);

  // A closed queue rejects a push before fullness is considered.
  assign push_closed = is_push && closed;
  assign push_full   = is_push && !closed && (count >= CNT_W'(DEPTH));
  assign push_ok     = is_push && !closed && (count < CNT_W'(DEPTH));
  assign pop_ok      = is_pop && (count != '0);

  assign cell_ctrl.shift = pop_ok;
  assign cell_ctrl.load  = push_ok;

  always_comb begin
    count_next = count;
    if (push_ok) begin
      count_next = count + 1'b1;
    end else if (pop_ok) begin
      count_next = count - 1'b1;
    end
  end

  assign peak_next   = (count_next > peak) ? count_next : peak;
  assign closed_next = closed || is_close;

  always_comb begin
    status_next    = cbf_pkg::ST_PUSHED;
    pop_value_next = '0;
    case (s_axis_tuser)
      cbf_pkg::CMD_PUSH: begin
        if (closed) begin
          status_next = cbf_pkg::ST_CLOSED_REJECT;
        end else if (count >= CNT_W'(DEPTH)) begin
          status_next = cbf_pkg::ST_FULL;
        end else begin
          status_next = cbf_pkg::ST_PUSHED;
        end
      end
      cbf_pkg::CMD_POP: begin
        if (count != '0) begin
          pop_value_next = cell_data[0];
          // The last value goes out once the queue is closed and drains.
          status_next = (closed && (count_next == '0)) ? cbf_pkg::ST_LAST
                                                       : cbf_pkg::ST_VALUE;
        end else begin
          status_next = closed ? cbf_pkg::ST_DONE : cbf_pkg::ST_EMPTY;
        end
      end
      default: begin
        status_next = cbf_pkg::ST_PUSHED;
      end
    endcase
  end

  cbf_sat_counter u_acc_cnt (
    .clk(clk), .rst(rst), .inc(push_ok), .value(acc_cnt), .value_next(acc_cnt_next)
  );
  cbf_sat_counter u_rcv_cnt (
    .clk(clk), .rst(rst), .inc(pop_ok), .value(rcv_cnt), .value_next(rcv_cnt_next)
  );
  cbf_sat_counter u_full_cnt (
    .clk(clk), .rst(rst), .inc(push_full), .value(full_cnt),
    .value_next(full_cnt_next)
  );
  cbf_sat_counter u_clsd_cnt (
    .clk(clk), .rst(rst), .inc(push_closed), .value(clsd_cnt),
    .value_next(clsd_cnt_next)
  );

  // Row of cells; the top cell takes zeros on a shift.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] upper;
    if (i == DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = cell_data[i+1];
    end
    cbf_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .CNT_W     (CNT_W),
      .INDEX     (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .count     (count),
      .push_data (push_value),
      .upper_data(upper),
      .data      (cell_data[i])
    );
  end

  always_comb begin
    result_word = '0;
    result_word[OUT_BITS-1:0] = {closed_next, clsd_cnt_next, full_cnt_next,
                                 rcv_cnt_next, acc_cnt_next, peak_next,
                                 count_next, pop_value_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      peak          <= '0;
      closed        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      count  <= count_next;
      peak   <= peak_next;
      closed <= closed_next;
      if (accept) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result payload; loaded only with an accepted command.
  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= result_word;
      m_axis_tuser <= status_next;
    end
  end

  // The occupancy never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("occupancy exceeds depth");

  // The peak never falls below the current occupancy.
  a_peak_covers: assert property (@(posedge clk) disable iff (rst)
    peak >= count)
    else $error("peak below occupancy");

  // Once closed, the queue stays closed until reset.
  a_closed_sticky: assert property (@(posedge clk) disable iff (rst)
    closed |=> closed)
    else $error("closed flag dropped");

  // A push into a closed queue reports a closed reject and keeps the occupancy.
  a_closed_push: assert property (@(posedge clk) disable iff (rst)
    push_closed |=> (m_axis_tuser == cbf_pkg::ST_CLOSED_REJECT) && $stable(count))
    else $error("closed push not rejected");

endmodule
